@@ rtl/lgs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lgs_pkg;

  localparam int NUM_CHIPS         = 2;
  localparam int CHANNELS_PER_CHIP = 24;
  localparam int TOTAL_CHANNELS    = NUM_CHIPS * CHANNELS_PER_CHIP;
  localparam int CH_W              = $clog2(TOTAL_CHANNELS);
  localparam int GRAY_W            = 12;
  localparam int BIT_W             = $clog2(GRAY_W);
  localparam int IDX_W             = 8;

  localparam logic [BIT_W-1:0] TOP_BIT      = BIT_W'(GRAY_W - 1);
  localparam logic [CH_W-1:0]  LAST_CHANNEL = CH_W'(TOTAL_CHANNELS - 1);
  localparam logic [IDX_W:0]   CHANNEL_LIMIT = (IDX_W + 1)'(TOTAL_CHANNELS);

  localparam logic [1:0] MODE_WRITE_ONE = 2'd0;
  localparam logic [1:0] MODE_WRITE_ALL = 2'd1;
  localparam logic [1:0] MODE_START     = 2'd2;
  localparam logic [1:0] MODE_TICK      = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE_ONE,
    OP_WRITE_ALL,
    OP_START,
    OP_TICK
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_SHIFT
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic              in_range;
    logic [CH_W-1:0]   addr;
    logic [GRAY_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic sin_bit;
    logic clock_pulse;
    logic latch_pulse;
    logic blank_level;
    logic write_accepted;
    logic frame_busy;
    logic frame_done;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/lgs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lgs_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               mode,
  input  wire logic [lgs_pkg::IDX_W-1:0]  led_index,
  input  wire logic [lgs_pkg::GRAY_W-1:0] gray_value,
  output logic                          q_valid,
  input  wire logic                     q_pop,
  output lgs_pkg::cmd_t                 q_cmd
);
  import lgs_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  // classify the incoming beat
  always_comb begin
    cmd_in.in_range = ({1'b0, led_index} < CHANNEL_LIMIT);
    cmd_in.addr     = led_index[CH_W-1:0];
    cmd_in.val      = gray_value;
    case (mode)
      MODE_WRITE_ONE: cmd_in.op = OP_WRITE_ONE;
      MODE_WRITE_ALL: cmd_in.op = OP_WRITE_ALL;
      MODE_START:     cmd_in.op = OP_START;
      default:        cmd_in.op = OP_TICK;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/lgs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lgs_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  output logic           q_pop,
  input  wire lgs_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lgs_pkg::res_t  out_res
);
  import lgs_pkg::*;

  back_state_t             state;
  back_state_t             state_next;
  logic                    frame_active;
  logic                    latch_pending;
  logic [CH_W-1:0]         channel_pointer;
  logic [BIT_W-1:0]        bit_pointer;
  logic [GRAY_W-1:0]       bcast_val;
  logic [TOTAL_CHANNELS-1:0] written;
  logic [GRAY_W-1:0]       gray_store [TOTAL_CHANNELS];
  logic [GRAY_W-1:0]       rd_data;
  logic                    rd_written;
  logic [GRAY_W-1:0]       word;

  logic out_free;
  logic rd_en;
  logic load;
  logic do_write_one;
  logic do_write_all;
  logic do_start;
  logic do_latch;
  logic do_shift;
  res_t res;

  assign out_free = !out_valid || out_ready;
  assign word     = rd_written ? rd_data : bcast_val;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && q_cmd.op == OP_TICK && frame_active && !latch_pending) begin
          state_next = BK_SHIFT;
        end
      end
      BK_SHIFT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    load         = 1'b0;
    do_write_one = 1'b0;
    do_write_all = 1'b0;
    do_start     = 1'b0;
    do_latch     = 1'b0;
    do_shift     = 1'b0;
    res          = '0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_TICK && frame_active && !latch_pending) begin
            q_pop = 1'b1;
            rd_en = 1'b1;
          end else if (out_free) begin
            q_pop          = 1'b1;
            load           = 1'b1;
            res.frame_busy = frame_active;
            case (q_cmd.op)
              OP_WRITE_ONE: begin
                do_write_one       = !frame_active && q_cmd.in_range;
                res.write_accepted = do_write_one;
              end
              OP_WRITE_ALL: begin
                do_write_all       = 1'b1;
                res.write_accepted = 1'b1;
              end
              OP_START: begin
                do_start       = !frame_active;
                res.frame_busy = 1'b1;
              end
              default: begin
                if (frame_active) begin
                  do_latch        = 1'b1;
                  res.latch_pulse = 1'b1;
                  res.blank_level = 1'b1;
                  res.frame_done  = 1'b1;
                  res.frame_busy  = 1'b0;
                end
              end
            endcase
          end
        end
      end
      BK_SHIFT: begin
        if (out_free) begin
          load            = 1'b1;
          do_shift        = 1'b1;
          res.sin_bit     = word[bit_pointer];
          res.clock_pulse = 1'b1;
          res.frame_busy  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // store entries not written since the last broadcast read as the broadcast value
  always_ff @(posedge clk) begin
    if (do_write_one) begin
      gray_store[q_cmd.addr] <= q_cmd.val;
    end
    if (rd_en) begin
      rd_data <= gray_store[channel_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BK_IDLE;
      frame_active    <= 1'b0;
      latch_pending   <= 1'b0;
      channel_pointer <= '0;
      bit_pointer     <= '0;
      bcast_val       <= '0;
      written         <= '0;
      rd_written      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (rd_en) begin
        rd_written <= written[channel_pointer];
      end
      if (do_write_all) begin
        bcast_val <= q_cmd.val;
        written   <= '0;
      end
      if (do_write_one) begin
        written[q_cmd.addr] <= 1'b1;
      end
      if (do_start) begin
        frame_active    <= 1'b1;
        channel_pointer <= LAST_CHANNEL;
        bit_pointer     <= TOP_BIT;
        latch_pending   <= 1'b0;
      end
      if (do_latch) begin
        frame_active  <= 1'b0;
        latch_pending <= 1'b0;
      end
      if (do_shift) begin
        if (bit_pointer == '0) begin
          if (channel_pointer == '0) begin
            latch_pending <= 1'b1;
          end else begin
            channel_pointer <= channel_pointer - CH_W'(1);
            bit_pointer     <= TOP_BIT;
          end
        end else begin
          bit_pointer <= bit_pointer - BIT_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/led_grayscale_serial_shifter_unit.sv @@
// grayscale store and serial shifter for a chain of 12-bit led driver chips
// input channel: in_valid/in_ready with mode, led_index, gray_value per beat
//   mode 0 writes one channel, 1 writes all, 2 starts a frame, 3 is a tick
// output channel: out_valid/out_ready, one result beat per input beat, in order
//   sin_bit, clock_pulse, latch_pulse, blank_level, write_accepted,
//   frame_busy, frame_done
// a two-entry queue sits between the decode front and the execute back
// throughput: one beat per cycle while out_ready allows, except a shifting
//   tick, which also passes through BK_SHIFT for the registered store read
// reset clears the store (by a broadcast value and per-channel written flags),
//   the frame state, the queue and the output valid flag; no clearing pass
// when out_ready is low the result holds, the back stops (but may still take
//   a shifting tick into BK_SHIFT), and the queue fills its two entries
`timescale 1ns / 1ps
`default_nettype none
module led_grayscale_serial_shifter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  led_index,
  input  wire logic [11:0] gray_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             sin_bit,
  output logic             clock_pulse,
  output logic             latch_pulse,
  output logic             blank_level,
  output logic             write_accepted,
  output logic             frame_busy,
  output logic             frame_done
);
  import lgs_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t out_res;

  lgs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .led_index  (led_index),
    .gray_value (gray_value),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd)
  );

  lgs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign sin_bit        = out_res.sin_bit;
  assign clock_pulse    = out_res.clock_pulse;
  assign latch_pulse    = out_res.latch_pulse;
  assign blank_level    = out_res.blank_level;
  assign write_accepted = out_res.write_accepted;
  assign frame_busy     = out_res.frame_busy;
  assign frame_done     = out_res.frame_done;

endmodule
`default_nettype wire
